// ===== rtl/core/scp_pkg.sv =====
`timescale 1ns / 1ps

package scp_pkg;

    // Unlock pattern, compared against the write shift register after each write
    localparam logic [63:0] UNLOCK_PATTERN = 64'h5ca33ac55ca33ac5;
    // Writes after the unlock that complete a clock-set
    localparam logic [6:0]  SET_LENGTH     = 7'd64;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic       write_bit;
        logic [5:0] now_seconds;
        logic [5:0] now_minutes;
        logic [4:0] now_hours;
        logic [2:0] now_weekday;
        logic [4:0] now_day;
        logic [3:0] now_month;
        logic [7:0] now_year;
    } item_t;

    typedef struct packed {
        logic        read_bit;
        logic        pattern_seen;
        logic        set_done;
        logic [63:0] set_word;
    } result_t;

    // Packed BCD of an 8-bit value, kept to 8 bits; v/10 as (v*205)>>11,
    // exact for every 8-bit v
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [18:0] prod;
        logic [7:0]  q;
        logic [7:0]  r;
        prod = {11'd0, v} * 19'd205;
        q    = prod[18:11];
        r    = v - 8'(q * 8'd10);
        return 8'({q[3:0], 4'b0000} + r);
    endfunction

endpackage

// ===== rtl/core/scp_time_word.sv =====
`timescale 1ns / 1ps

module scp_time_word
    import scp_pkg::*;
(
    input  item_t       item,
    output logic [63:0] time_word
);

    logic [7:0] month_adj;

    assign month_adj = 8'({4'd0, item.now_month} + 8'd1);

    // bytes low to high: hundredths, sec, min, hour, weekday, day, month, year
    assign time_word = {
        to_bcd(item.now_year),
        to_bcd(month_adj),
        to_bcd({3'd0, item.now_day}),
        to_bcd({5'd0, item.now_weekday}),
        to_bcd({3'd0, item.now_hours}),
        to_bcd({2'd0, item.now_minutes}),
        to_bcd({2'd0, item.now_seconds}),
        8'h00
    };

endmodule

// ===== rtl/core/scp_engine.sv =====
`timescale 1ns / 1ps

module scp_engine
    import scp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    proc,     // item in the input register is consumed this cycle
    input  item_t   item,
    output result_t res
);

    logic [63:0] write_shift_reg, write_shift_next;
    logic [63:0] read_shift_reg,  read_shift_next;
    logic [6:0]  set_count_reg,   set_count_next;
    logic [63:0] wsh_shifted;
    logic [63:0] time_word;
    logic        match;

    scp_time_word u_time_word (
        .item      (item),
        .time_word (time_word)
    );

    assign wsh_shifted = {item.write_bit, write_shift_reg[63:1]};
    assign match       = (wsh_shifted == UNLOCK_PATTERN);

    always_comb begin
        write_shift_next = write_shift_reg;
        read_shift_next  = read_shift_reg;
        set_count_next   = set_count_reg;
        res              = '0;
        if (proc) begin
            if (item.command == CMD_READ) begin
                res.read_bit    = read_shift_reg[0];
                read_shift_next = {1'b0, read_shift_reg[63:1]};
            end else begin
                write_shift_next = wsh_shifted;
                if (match) begin
                    // pattern wins over a pending set completion
                    set_count_next   = 7'd1;
                    read_shift_next  = time_word;
                    res.pattern_seen = 1'b1;
                end else if (set_count_reg != 7'd0) begin
                    if (set_count_reg >= SET_LENGTH) begin
                        set_count_next = 7'd0;
                        res.set_done   = 1'b1;
                        res.set_word   = wsh_shifted;
                    end else begin
                        set_count_next = set_count_reg + 7'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_shift_reg <= '0;
            read_shift_reg  <= '0;
            set_count_reg   <= '0;
        end else begin
            write_shift_reg <= write_shift_next;
            read_shift_reg  <= read_shift_next;
            set_count_reg   <= set_count_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        set_count_reg <= SET_LENGTH)
        else $error("set count beyond set length");

    a_unlock_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && item.command == CMD_WRITE && match |=> set_count_reg == 7'd1)
        else $error("unlock did not arm the count");

    a_read_keeps_write: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && item.command == CMD_READ |=> $stable(write_shift_reg) && $stable(set_count_reg))
        else $error("read disturbed write state");

    a_done_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        res.set_done |=> set_count_reg == 7'd0)
        else $error("count not cleared after set");

endmodule

// ===== rtl/core/serial_clock_pattern_unlock_top.sv =====
`timescale 1ns / 1ps

// Serial calendar register with a 64-bit unlock pattern. Every transaction is
// one bus access: a write shifts one bit into a 64-bit write register, and when
// that register matches the unlock pattern the current time (given in binary on
// the input) is latched as packed BCD into a read register and a 64-write
// clock-set count arms; the 64th following write reports the write register as
// the set word. A read returns the next time bit, LSB first. One result per
// transaction. Throughput is one per clock unless m_tready stalls; items pass
// the input register, then the result register, and the state registers
// update as each item leaves the input register. Both sides may stall freely.
module serial_clock_pattern_unlock_top
    import scp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] write_bit, [6:1] now_seconds, [12:7] now_minutes, [17:13] now_hours,
    // [20:18] now_weekday, [25:21] now_day, [29:26] now_month, [37:30] now_year,
    // [39:38] zero
    input  logic [39:0] s_tdata,
    // [0] command (0 read, 1 write)
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] read_bit, [64:1] set_word, [71:65] zero
    output logic [71:0] m_tdata,
    // [0] pattern_seen, [1] set_done
    output logic [1:0]  m_tuser
);

    item_t   s_item;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg, in_valid_next;
    result_t out_res_reg, out_res_next;
    logic    out_valid_reg, out_valid_next;
    result_t res;
    logic    adv;     // result register free to take the next result
    logic    s_fire;

    // unpack the incoming transaction
    assign s_item.command     = cmd_t'(s_tuser[0]);
    assign s_item.write_bit   = s_tdata[0];
    assign s_item.now_seconds = s_tdata[6:1];
    assign s_item.now_minutes = s_tdata[12:7];
    assign s_item.now_hours   = s_tdata[17:13];
    assign s_item.now_weekday = s_tdata[20:18];
    assign s_item.now_day     = s_tdata[25:21];
    assign s_item.now_month   = s_tdata[29:26];
    assign s_item.now_year    = s_tdata[37:30];

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    // state update and result logic for the item in the input register
    scp_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (in_valid_reg && adv),
        .item    (in_item_reg),
        .res     (res)
    );

    always_comb begin
        in_item_next   = in_item_reg;
        in_valid_next  = in_valid_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (s_fire) begin
            in_item_next  = s_item;
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
        if (adv) begin
            out_res_next   = res;
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.set_word, out_res_reg.read_bit};
    assign m_tuser  = {out_res_reg.set_done, out_res_reg.pattern_seen};

endmodule
